@@ hdl/plist_pkg.sv @@
// Shared types and constants for the positional list store.
package plist_pkg;

    localparam int DEF_DEPTH         = 16;
    localparam int DEF_ELEMENT_WIDTH = 16;
    localparam int POS_W             = 5;
    localparam int VALUE_W           = 16;
    localparam int LENGTH_W          = 5;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } stat_t;

    // Read address relative to the working pointer.
    typedef enum logic [1:0] {
        FS_PTR   = 2'd0,
        FS_BELOW = 2'd1,
        FS_ABOVE = 2'd2
    } fetch_sel_t;

    typedef struct packed {
        logic       load;
        logic       fetch;
        fetch_sel_t fetch_sel;
        logic       store;
        logic       store_value;
        logic       ptr_up;
        logic       ptr_down;
        logic       len_inc;
        logic       len_dec;
    } ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic ok;
        logic at_end;
        logic near_end;
    } sts_t;

endpackage

@@ hdl/plist_ctrl.sv @@
// Sequencer for the positional list store: decode, element moves, response.
module plist_ctrl
    import plist_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output ctl_t ctl,
    output logic busy,
    output logic done
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECIDE   = 7'b0000010,
        S_FETCH    = 7'b0000100,
        S_SHIFT_RD = 7'b0001000,
        S_SHIFT_WR = 7'b0010000,
        S_PUT      = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.fetch_sel = FS_PTR;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!sts.ok)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    case (sts.cmd)
                        CMD_READ:   state_next = S_FETCH;
                        CMD_WRITE:  state_next = S_PUT;
                        CMD_INSERT: state_next = sts.at_end ? S_PUT : S_SHIFT_RD;
                        CMD_DELETE:
                        begin
                            if (sts.at_end)
                            begin
                                ctl.len_dec = 1'b1;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SHIFT_RD;
                            end
                        end
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_FETCH:
            begin
                ctl.fetch  = 1'b1;
                state_next = S_RESP;
            end
            S_SHIFT_RD:
            begin
                // insert pulls from below, delete from above
                ctl.fetch     = 1'b1;
                ctl.fetch_sel = (sts.cmd == CMD_INSERT) ? FS_BELOW : FS_ABOVE;
                state_next    = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                ctl.store = 1'b1;
                if (sts.cmd == CMD_INSERT)
                begin
                    ctl.ptr_down = 1'b1;
                    state_next   = sts.near_end ? S_PUT : S_SHIFT_RD;
                end
                else
                begin
                    ctl.ptr_up = 1'b1;
                    if (sts.near_end)
                    begin
                        ctl.len_dec = 1'b1;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
            end
            S_PUT:
            begin
                ctl.store       = 1'b1;
                ctl.store_value = 1'b1;
                ctl.len_inc     = (sts.cmd == CMD_INSERT);
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

endmodule

@@ hdl/plist_dp.sv @@
// Datapath for the positional list store: element memory, length and pointers.
module plist_dp
    import plist_pkg::*;
#(
    parameter int DEPTH         = DEF_DEPTH,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                ctl,
    input  logic [1:0]          command,
    input  logic [POS_W-1:0]    position,
    input  logic [VALUE_W-1:0]  value,
    output sts_t                sts,
    output logic [VALUE_W-1:0]  read_value,
    output logic [1:0]          status,
    output logic [LENGTH_W-1:0] length
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int CW    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    cmd_t                     cmd_reg;
    stat_t                    stat_reg;
    logic [AW-1:0]            k_reg;
    logic [AW-1:0]            ptr_reg;
    logic [ELEMENT_WIDTH-1:0] val_reg;
    logic [ELEMENT_WIDTH-1:0] rdata_reg;

    logic [CW-1:0]            pos_ext;
    logic [CW-1:0]            len_ext;
    logic [CW-1:0]            k_ext;
    logic                     in_list;
    stat_t                    chk;
    logic [AW-1:0]            ptr_init;
    logic [AW-1:0]            rd_addr;
    logic [ELEMENT_WIDTH-1:0] wdata;
    logic [CW-1:0]            ptr_ext;

    assign pos_ext = CW'(position);
    assign len_ext = CW'(len_reg);
    assign in_list = (position != '0) && (pos_ext <= len_ext);
    assign k_ext   = pos_ext - CW'(1);

    // Check the command against the current length at accept time.
    always_comb
    begin
        chk      = ST_DONE;
        ptr_init = k_ext[AW-1:0];
        case (cmd_t'(command))
            CMD_READ,
            CMD_WRITE,
            CMD_DELETE:
            begin
                if (!in_list)
                begin
                    chk = ST_BAD;
                end
            end
            CMD_INSERT:
            begin
                ptr_init = len_reg[AW-1:0];
                if (len_ext >= CW'(DEPTH))
                begin
                    chk = ST_FULL;
                end
                else if ((position == '0) || (pos_ext > len_ext + CW'(1)))
                begin
                    chk = ST_BAD;
                end
            end
            default:
            begin
                chk = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd_t'(command);
            stat_reg <= chk;
            k_reg    <= k_ext[AW-1:0];
            val_reg  <= ELEMENT_WIDTH'(value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ptr_reg <= ptr_init;
        end
        else if (ctl.ptr_up)
        begin
            ptr_reg <= ptr_reg + AW'(1);
        end
        else if (ctl.ptr_down)
        begin
            ptr_reg <= ptr_reg - AW'(1);
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (ctl.len_inc)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        else if (ctl.len_dec)
        begin
            len_next = len_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_comb
    begin
        case (ctl.fetch_sel)
            FS_BELOW: rd_addr = ptr_reg - AW'(1);
            FS_ABOVE: rd_addr = ptr_reg + AW'(1);
            default:  rd_addr = ptr_reg;
        endcase
    end

    assign wdata = ctl.store_value ? val_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.store)
        begin
            mem[ptr_reg] <= wdata;
        end
        if (ctl.fetch)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign ptr_ext = CW'(ptr_reg);

    // Loop-end flags: insert walks down to k, delete walks up to length - 1.
    always_comb
    begin
        sts.cmd = cmd_reg;
        sts.ok  = (stat_reg == ST_DONE);
        if (cmd_reg == CMD_INSERT)
        begin
            sts.at_end   = (ptr_reg == k_reg);
            sts.near_end = (ptr_ext == CW'(k_reg) + CW'(1));
        end
        else
        begin
            sts.at_end   = (ptr_ext == len_ext - CW'(1));
            sts.near_end = (ptr_ext + CW'(1) == len_ext - CW'(1));
        end
    end

    assign read_value = ((cmd_reg == CMD_READ) && (stat_reg == ST_DONE))
                        ? VALUE_W'(rdata_reg) : '0;
    assign status     = stat_reg;
    assign length     = LENGTH_W'(len_reg);

endmodule

@@ hdl/positional_list_store_top.sv @@
// Top level of the positional list store.
//
// A command word is taken when start is high and busy is low; its result
// appears for one cycle with done high, and must be taken then. Elements
// live in a memory with one write and one registered read per cycle, and a
// shift moves one element in two steps (read, then write). Insert and delete
// at position p of a list of length L shift L - p + 1 and L - p elements,
// so they take longer the nearer p lies to the head of the list.
// The list is empty after reset; no clearing pass is needed.
module positional_list_store_top
    import plist_pkg::*;
#(
    parameter int DEPTH         = DEF_DEPTH,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          command,
    input  logic [POS_W-1:0]    position,
    input  logic [VALUE_W-1:0]  value,
    output logic                done,
    output logic [VALUE_W-1:0]  read_value,
    output logic [1:0]          status,
    output logic [LENGTH_W-1:0] length
);

    ctl_t ctl;
    sts_t sts;

    plist_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    plist_dp #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .command    (command),
        .position   (position),
        .value      (value),
        .sts        (sts),
        .read_value (read_value),
        .status     (status),
        .length     (length)
    );

endmodule

@@ hdl/plist_chk.sv @@
// Port-level checker for the positional list store, bound to the top level.
module plist_chk
    import plist_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [VALUE_W-1:0]  read_value,
    input logic [1:0]          status
);

    // A result word only shows while a command is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // An accepted command holds the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_DONE || status == ST_FULL || status == ST_BAD))
        else $error("undefined status code");

    // A refused command returns no element.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_DONE) |-> (read_value == '0))
        else $error("read value on a refused command");

endmodule

bind positional_list_store_top plist_chk u_plist_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .read_value (read_value),
    .status     (status)
);
